// File: rtl/subpel_interp_fir_8tap_core_defines.svh
// Assertion macros used by the checker file of the interpolation filter core
`ifndef SUBPEL_INTERP_FIR_8TAP_CORE_DEFINES_SVH
`define SUBPEL_INTERP_FIR_8TAP_CORE_DEFINES_SVH

// Same-cycle implication, masked while reset is asserted
`define SIFIR_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, masked while reset is asserted
`define SIFIR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

// Next-cycle implication that is also checked through reset
`define SIFIR_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/sifir_pkg.sv
// Shared types and constants of the sub-pixel interpolation filter core
`default_nettype none

package sifir_pkg;

  // window and coefficient geometry
  localparam int NUM_TAPS      = 8;
  localparam int TAP_IDX_W     = $clog2(NUM_TAPS);
  localparam int CFG_IDX_W     = TAP_IDX_W + 1;
  localparam int SAMPLE_W      = 16;
  localparam int COEF_W        = 8;
  localparam int KIND_W        = 3;

  // accumulation widths: product, pair sum, full dot product
  localparam int PROD_W        = SAMPLE_W + COEF_W;
  localparam int PAIR_W        = PROD_W + 1;
  localparam int SUM_W         = PROD_W + TAP_IDX_W;

  // default pixel depth
  localparam int PIXEL_DEPTH_DEF = 8;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef sample_t [NUM_TAPS-1:0]     sample_vec_t;
  typedef coef_t   [NUM_TAPS-1:0]     coef_vec_t;

  // filter modes
  typedef enum logic [KIND_W-1:0] {
    KIND_HPP = 3'd0,  // horizontal pixel to pixel
    KIND_VPP = 3'd1,  // vertical pixel to pixel
    KIND_HPS = 3'd2,  // horizontal pixel to intermediate
    KIND_VPS = 3'd3,  // vertical pixel to intermediate
    KIND_VSP = 3'd4,  // vertical intermediate to pixel
    KIND_VSS = 3'd5   // vertical intermediate to intermediate
  } kind_t;

  // dot product word handed to the rounding stage
  typedef struct packed {
    kind_t                   kind;
    logic signed [SUM_W-1:0] sum;
  } sum_word_t;

endpackage

`default_nettype wire

// File: rtl/subpel_interp_fir_8tap_core.sv
// Top level of the 8-tap sub-pixel interpolation filter core
`default_nettype none

// Sub-pixel interpolation filter: each input word carries an eight-sample
// window (in_tdata) and a filter mode (in_tuser); the core returns one
// 16-bit filtered sample per word, zero for modes 6 and 7. It takes one
// word per clock and keeps that rate as long as out_tready stays high; a
// word passes the multiply, pair-add and final-add stages, then the
// rounding, shift and clip stage that feeds the output register.
// Coefficients go over the cfg port, index 0 to 7; the user must write
// them only while no word is in flight (unchecked by the core). A 4-tap
// chroma filter uses zeros in taps 4 to 7; reset sets the identity (tap 3 = 64).

module subpel_interp_fir_8tap_core #(
  parameter int PIXEL_DEPTH = sifir_pkg::PIXEL_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [127:0]                    in_tdata,   // win_s0 .. win_s7, 16 bits each
  input  logic [sifir_pkg::KIND_W-1:0]    in_tuser,   // kind
  // result stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [15:0]                     out_tdata,  // filtered
  // coefficient writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [sifir_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sifir_pkg::COEF_W-1:0]    cfg_data
);
  import sifir_pkg::*;

  localparam int FILTER_PREC   = 6;
  localparam int INTERNAL_PREC = 14;
  localparam int INTERNAL_OFFS = 8192;
  localparam int HEAD_ROOM     = INTERNAL_PREC - PIXEL_DEPTH;
  localparam int PS_SHIFT      = FILTER_PREC - HEAD_ROOM;
  localparam int SP_SHIFT      = FILTER_PREC + HEAD_ROOM;
  localparam int ACC_W         = SUM_W + 1;
  localparam int OUT_W         = SAMPLE_W;

  localparam logic signed [ACC_W-1:0] RND_FP   = ACC_W'(1 << (FILTER_PREC - 1));
  localparam logic signed [ACC_W-1:0] OFFS_PS  = ACC_W'(INTERNAL_OFFS << PS_SHIFT);
  localparam logic signed [ACC_W-1:0] OFFS_SP  =
    ACC_W'((1 << (SP_SHIFT - 1)) + (INTERNAL_OFFS << FILTER_PREC));
  localparam logic signed [OUT_W-1:0] PIX_MAX  = OUT_W'((1 << PIXEL_DEPTH) - 1);

  coef_vec_t               coef_r;
  sample_vec_t             samp;
  logic                    sum_valid, sum_ready;
  sum_word_t               sum_word;
  logic                    out_valid_r;
  logic [OUT_W-1:0]        out_data_r;
  logic [OUT_W-1:0]        res_nxt;

  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] add_rnd, add_ps, add_sp;
  logic signed [ACC_W-1:0] sh_rnd, sh_ps, sh_sp, sh_plain;
  logic signed [OUT_W-1:0] t_hpp, t_hps;
  logic signed [OUT_W-1:0] r_hpp, r_vpp, r_hps, r_vps, r_vsp, r_vss;

  function automatic logic signed [OUT_W-1:0] clip_pix(input logic signed [OUT_W-1:0] v);
    if (v[OUT_W-1]) return '0;
    if (v > PIX_MAX) return PIX_MAX;
    return v;
  endfunction

  // coefficient registers, identity filter after reset
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_TAPS; i++) begin
        coef_r[i] <= '0;
      end
      coef_r[3] <= COEF_W'(64);
    end else if (cfg_valid && (cfg_index < CFG_IDX_W'(NUM_TAPS))) begin
      coef_r[cfg_index[TAP_IDX_W-1:0]] <= cfg_data;
    end
  end

  // unpack window
  always_comb begin
    for (int i = 0; i < NUM_TAPS; i++) begin
      samp[i] = in_tdata[i*SAMPLE_W +: SAMPLE_W];
    end
  end

  sifir_dot u_dot (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_kind   (kind_t'(in_tuser)),
    .in_samp   (samp),
    .in_coef   (coef_r),
    .sum_valid (sum_valid),
    .sum_ready (sum_ready),
    .sum_word  (sum_word)
  );

  // rounding, shift, truncation and clip per mode
  always_comb begin
    acc      = ACC_W'(sum_word.sum);
    add_rnd  = acc + RND_FP;
    add_ps   = acc - OFFS_PS;
    add_sp   = acc + OFFS_SP;
    sh_rnd   = add_rnd >>> FILTER_PREC;
    sh_ps    = add_ps >>> PS_SHIFT;
    sh_sp    = add_sp >>> SP_SHIFT;
    sh_plain = acc >>> FILTER_PREC;
    // horizontal modes truncate before the shift
    t_hpp    = add_rnd[OUT_W-1:0];
    t_hps    = add_ps[OUT_W-1:0];
    r_hpp    = clip_pix(t_hpp >>> FILTER_PREC);
    r_vpp    = clip_pix(sh_rnd[OUT_W-1:0]);
    r_hps    = t_hps >>> PS_SHIFT;
    r_vps    = sh_ps[OUT_W-1:0];
    r_vsp    = clip_pix(sh_sp[OUT_W-1:0]);
    r_vss    = sh_plain[OUT_W-1:0];
    case (sum_word.kind)
      KIND_HPP: res_nxt = r_hpp;
      KIND_VPP: res_nxt = r_vpp;
      KIND_HPS: res_nxt = r_hps;
      KIND_VPS: res_nxt = r_vps;
      KIND_VSP: res_nxt = r_vsp;
      KIND_VSS: res_nxt = r_vss;
      default:  res_nxt = '0;
    endcase
  end

  // output register
  assign sum_ready = !out_valid_r || out_tready;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (sum_ready) begin
      out_valid_r <= sum_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sum_ready) begin
      out_data_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

// File: rtl/sifir_dot.sv
// Three-stage pipelined 8-tap dot product: multiply, pair add, final add
`default_nettype none

module sifir_dot (
  input  logic                   clk,
  input  logic                   rst_n,
  // incoming window word
  input  logic                   in_valid,
  output logic                   in_ready,
  input  sifir_pkg::kind_t       in_kind,
  input  sifir_pkg::sample_vec_t in_samp,
  input  sifir_pkg::coef_vec_t   in_coef,
  // dot product word
  output logic                   sum_valid,
  input  logic                   sum_ready,
  output sifir_pkg::sum_word_t   sum_word
);
  import sifir_pkg::*;

  localparam int NUM_PAIRS = NUM_TAPS / 2;

  logic                     v1_r, v2_r, v3_r;
  logic                     rdy1, rdy2, rdy3;
  logic signed [PROD_W-1:0] prod_r [NUM_TAPS];
  logic signed [PROD_W-1:0] prod_nxt [NUM_TAPS];
  logic signed [PAIR_W-1:0] pair_r [NUM_PAIRS];
  logic signed [PAIR_W-1:0] pair_nxt [NUM_PAIRS];
  logic signed [SUM_W-1:0]  sum_r;
  logic signed [SUM_W-1:0]  sum_nxt;
  kind_t                    kind1_r, kind2_r, kind3_r;

  // a stage takes a new word when empty or when its word moves on
  assign rdy3     = !v3_r || sum_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  // products of window samples and coefficients
  always_comb begin
    for (int i = 0; i < NUM_TAPS; i++) begin
      prod_nxt[i] = PROD_W'(in_samp[i]) * PROD_W'(in_coef[i]);
    end
  end

  // adjacent pairs summed
  always_comb begin
    for (int j = 0; j < NUM_PAIRS; j++) begin
      pair_nxt[j] = PAIR_W'(prod_r[2*j]) + PAIR_W'(prod_r[2*j+1]);
    end
  end

  // remaining pair sums folded
  always_comb begin
    sum_nxt = '0;
    for (int j = 0; j < NUM_PAIRS; j++) begin
      sum_nxt = sum_nxt + SUM_W'(pair_r[j]);
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (rdy1) begin
      prod_r  <= prod_nxt;
      kind1_r <= in_kind;
    end
    if (rdy2) begin
      pair_r  <= pair_nxt;
      kind2_r <= kind1_r;
    end
    if (rdy3) begin
      sum_r   <= sum_nxt;
      kind3_r <= kind2_r;
    end
  end

  assign sum_valid = v3_r;
  assign sum_word  = '{kind: kind3_r, sum: sum_r};

endmodule

`default_nettype wire

// File: rtl/sifir_checker.sv
// Port-level checks of the interpolation filter core and their binding
`default_nettype none

`include "subpel_interp_fir_8tap_core_defines.svh"

module sifir_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [15:0] out_tdata
);

  // a stalled result word stays offered
  `SIFIR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid)

  // an empty output means the pipeline can take a word
  `SIFIR_ASSERT_IMPLY(a_in_ready_idle, clk, rst_n, !out_tvalid, in_tready)

  // reset empties the output register
  `SIFIR_ASSERT_NEXT_ALWAYS(a_rst_empty, clk, !rst_n, !out_tvalid)

  // a stalled result word keeps its data
  `SIFIR_ASSERT_NEXT(a_out_stable, clk, rst_n, out_tvalid && !out_tready, $stable(out_tdata))

endmodule

bind subpel_interp_fir_8tap_core sifir_checker u_sifir_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
